>>> rtl/ir_distance_linearize_average_defines.svh
// assertion macros for the ir distance linearizer block
// clocked on clk_i; IDLA_ASSERT is disabled while rst_ni is low, IDLA_ASSERT_ALWAYS is not
`ifndef IR_DISTANCE_LINEARIZE_AVERAGE_DEFINES_SVH
`define IR_DISTANCE_LINEARIZE_AVERAGE_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define IDLA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define IDLA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define IDLA_ASSERT(lbl, prop, msg)

`define IDLA_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> rtl/idla_pkg.sv
// constants, types and segment table for the ir distance linearizer
// no dependencies
`timescale 1ns / 1ps

package idla_pkg;

  localparam int CHANNELS  = 6;
  localparam int AVG_COUNT = 10;

  localparam int CH_W      = 3;
  localparam int CODE_W    = 12;
  localparam int DIST_W    = 7;
  localparam int SUM_W     = 10;
  localparam int CNT_W     = 4;
  localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_EXT_W  = 5;

  localparam int ICPT_W    = 24;
  localparam int SLOPE_W   = 14;
  localparam int PROD_W    = SLOPE_W + CODE_W;
  localparam int DIFF_W    = PROD_W + 1;
  localparam int FRAC_W    = 16;

  // mean by reciprocal multiply, exact for any sum below 2**SUM_W
  localparam int DIV_SHIFT = 20;
  localparam int RECIP_W   = DIV_SHIFT + 1;
  localparam logic [RECIP_W-1:0] DIV_RECIP =
    RECIP_W'(((1 << DIV_SHIFT) + AVG_COUNT - 1) / AVG_COUNT);
  localparam int QUOT_W    = SUM_W + RECIP_W;

  localparam int SEG_N = 6;
  localparam logic [CODE_W-1:0] CODE_NEAR = 12'd2978;

  localparam logic [CODE_W-1:0]  SEG_ABOVE [SEG_N] =
    '{12'd1700, 12'd1116, 12'd980, 12'd856, 12'd620, 12'd546};
  localparam logic [ICPT_W-1:0]  SEG_ICPT  [SEG_N] =
    '{24'd2182349, 24'd3221094, 24'd7328236, 24'd7798784, 24'd5657068, 24'd11796480};
  localparam logic [SLOPE_W-1:0] SEG_SLOPE [SEG_N] =
    '{14'd513, 14'd1123, 14'd4801, 14'd5281, 14'd2780, 14'd13203};

  localparam logic [ICPT_W-1:0] ICPT_NEAR = ICPT_W'(10 << FRAC_W);
  localparam logic [ICPT_W-1:0] ICPT_FAR  = ICPT_W'(80 << FRAC_W);

  typedef struct packed {
    logic [ICPT_W-1:0]  icpt;
    logic [SLOPE_W-1:0] slope;
  } seg_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
  } ent_t;

  // first matching segment wins, flat ends carry a zero slope
  function automatic seg_t seg_coef(input logic [CODE_W-1:0] code);
    seg_t res;
    res.icpt  = ICPT_FAR;
    res.slope = '0;
    for (int i = SEG_N - 1; i >= 0; i--) begin
      if (code > SEG_ABOVE[i]) begin
        res.icpt  = SEG_ICPT[i];
        res.slope = SEG_SLOPE[i];
      end
    end
    if (code > CODE_NEAR) begin
      res.icpt  = ICPT_NEAR;
      res.slope = '0;
    end
    return res;
  endfunction

endpackage

>>> rtl/ir_distance_linearize_average.sv
// ir distance linearizer with per-channel averaging, top level
// uses idla_pkg and ir_distance_linearize_average_defines.svh
`timescale 1ns / 1ps

// Takes one sample per cycle (channel on tuser, 12-bit converter code on tdata) unless stalled,
// maps the code to whole centimetres through a piecewise-linear segment table, and accumulates
// per channel. Every AVG_COUNT samples of a channel it sends the truncated mean on the output
// stream and clears that channel. Channels at or above CHANNELS are dropped. Throughput is one
// sample per cycle while not stalled; a result passes through stage 1, stage 2 and the output
// register. The per-channel sums and counts live in a small synchronous memory that is read one
// stage ahead and written back the stage after, with a bypass when back-to-back samples hit one
// channel. The input stalls only when a sample completing an average meets a result that is
// still waiting to be taken. Reset clears all channels at once.
module ir_distance_linearize_average (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [15:0]                 s_axis_tdata,  // [11:0] sample_code, rest zero
  input  logic [idla_pkg::CH_W-1:0]   s_axis_tuser,  // [2:0] channel
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,  // [6:0] average_distance_cm, rest zero
  output logic [idla_pkg::CH_W-1:0]   m_axis_tuser   // [2:0] out_channel
);
  import idla_pkg::*;

  `include "ir_distance_linearize_average_defines.svh"

  logic                 adv;
  logic [CH_EXT_W-1:0]  in_ch_ext;

  // stage 1: registered input
  logic                 s1_vld_q;
  logic [CH_W-1:0]      s1_ch_q;
  logic [CH_IDX_W-1:0]  s1_idx_q;
  logic [CODE_W-1:0]    s1_code_q;
  seg_t                 s1_seg;
  logic [PROD_W-1:0]    s1_prod;

  // stage 2: product and memory read data
  logic                 s2_vld_q;
  logic [CH_W-1:0]      s2_ch_q;
  logic [CH_IDX_W-1:0]  s2_idx_q;
  logic [ICPT_W-1:0]    s2_icpt_q;
  logic [PROD_W-1:0]    s2_prod_q;
  logic                 s2_rvld_q;
  ent_t                 s2_rdata_q;
  logic                 fwd_q;
  ent_t                 fwd_data_q;

  logic [DIFF_W-1:0]    s2_diff;
  logic [DIST_W-1:0]    s2_dist;
  ent_t                 s2_old;
  ent_t                 s2_new;
  logic                 s2_emit;
  ent_t                 wr_data;
  logic                 wr_en;
  logic [QUOT_W-1:0]    s2_quot;

  ent_t                 mem_q [CHANNELS];
  logic [CHANNELS-1:0]  ent_vld_q;

  logic                 out_vld_q;
  logic [CH_W-1:0]      out_ch_q;
  logic [DIST_W-1:0]    out_avg_q;

  // stall only when a finishing sample would overwrite a held result
  assign adv = !(s2_vld_q && s2_emit && out_vld_q && !m_axis_tready);
  assign s_axis_tready = adv;

  assign in_ch_ext = CH_EXT_W'(s_axis_tuser);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= s_axis_tvalid && (in_ch_ext < CH_EXT_W'(CHANNELS));
      s2_vld_q <= s1_vld_q;
      fwd_q    <= wr_en && s1_vld_q && (s2_idx_q == s1_idx_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ch_q    <= s_axis_tuser;
      s1_idx_q   <= CH_IDX_W'(in_ch_ext);
      s1_code_q  <= s_axis_tdata[CODE_W-1:0];
      s2_ch_q    <= s1_ch_q;
      s2_idx_q   <= s1_idx_q;
      s2_icpt_q  <= s1_seg.icpt;
      s2_prod_q  <= s1_prod;
      fwd_data_q <= wr_data;
    end
  end

  assign s1_seg  = seg_coef(s1_code_q);
  assign s1_prod = PROD_W'(s1_seg.slope) * PROD_W'(s1_code_q);

  // memory read, registered into stage 2
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_rdata_q <= mem_q[s1_idx_q];
      s2_rvld_q  <= ent_vld_q[s1_idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[s2_idx_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
    end else if (wr_en) begin
      ent_vld_q[s2_idx_q] <= 1'b1;
    end
  end

  // stage 2 arithmetic: line value, accumulate, mean
  always_comb begin
    s2_diff = DIFF_W'(s2_icpt_q) - DIFF_W'(s2_prod_q);
    s2_dist = s2_diff[DIFF_W-1] ? '0 : s2_diff[FRAC_W+DIST_W-1:FRAC_W];
    if (fwd_q) begin
      s2_old = fwd_data_q;
    end else if (s2_rvld_q) begin
      s2_old = s2_rdata_q;
    end else begin
      s2_old = '0;
    end
    s2_new.sum = s2_old.sum + SUM_W'(s2_dist);
    s2_new.cnt = s2_old.cnt + CNT_W'(1);
    s2_emit    = (s2_new.cnt >= CNT_W'(AVG_COUNT));
    wr_data    = s2_emit ? '0 : s2_new;
    wr_en      = adv && s2_vld_q;
    s2_quot    = QUOT_W'(s2_new.sum) * QUOT_W'(DIV_RECIP);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (wr_en && s2_emit) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && s2_emit) begin
      out_ch_q  <= s2_ch_q;
      out_avg_q <= s2_quot[DIV_SHIFT+DIST_W-1:DIV_SHIFT];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_ch_q;
  assign m_axis_tdata  = {1'b0, out_avg_q};

  `IDLA_ASSERT(a_emit_reaches_out, (wr_en && s2_emit) |=> m_axis_tvalid,
               "finished average did not reach the output register")
  `IDLA_ASSERT(a_cnt_below_avg, wr_en |-> (wr_data.cnt < CNT_W'(AVG_COUNT)),
               "stored sample count reached the averaging length")
  `IDLA_ASSERT(a_avg_range, m_axis_tvalid |-> (out_avg_q <= DIST_W'(80)),
               "average distance above the far limit")
  `IDLA_ASSERT_ALWAYS(a_no_fwd_in_reset, !rst_ni |=> !fwd_q,
                      "bypass active during reset")

endmodule
